// ===== rtl/eci_pkg.sv =====
// package: widths, pipeline types and rounding helper for the circle intersection block
`timescale 1ns / 1ps

package eci_pkg;

    localparam int CW   = 24;        // coordinate and radius width
    localparam int SW   = CW + 1;    // sum of two coordinates
    localparam int C2W  = 2 * CW;    // squared coordinate difference
    localparam int D2W  = 2 * CW + 2;// squared distance and (2r)^2
    localparam int RHW  = C2W + D2W; // c^2 * rem
    localparam int QW   = CW + 2;    // root bits
    localparam int AW   = RHW + 6;   // running q^2*d2 and q*d2
    localparam int OW   = 26;        // result coordinate width
    localparam int LO_W = CW + 1;    // low half of rem
    localparam int PPW  = CW + LO_W; // one partial product
    localparam int LATENCY = 32;

    typedef struct packed {
        logic           found;
        logic           dx_neg;
        logic           dy_neg;
        logic [SW-1:0]  sum_x;
        logic [SW-1:0]  sum_y;
        logic [D2W-1:0] d2;
        logic [RHW-1:0] rhs_x;
        logic [RHW-1:0] rhs_y;
        logic [AW-1:0]  s_x;
        logic [AW-1:0]  p_x;
        logic [QW-1:0]  q_x;
        logic [AW-1:0]  s_y;
        logic [AW-1:0]  p_y;
        logic [QW-1:0]  q_y;
    } root_t;

    // (sum +/- w) / 2 rounded, ties away from zero, w = q plus a fraction unless exact
    function automatic logic signed [OW-1:0] half_round(
        input logic [SW-1:0] sum,
        input logic [QW-1:0] q,
        input logic          neg,
        input logic          exact
    );
        logic [QW:0] s1;
        logic [QW:0] q1;
        logic [QW:0] n;
        logic [QW:0] h;
        logic        minus;
        s1    = (QW+1)'(sum);
        q1    = (QW+1)'(q);
        minus = 1'b0;
        if (!neg) begin
            n = s1 + q1;
        end else if (exact ? (s1 >= q1) : (s1 > q1)) begin
            n = s1 - q1 - (exact ? (QW+1)'(0) : (QW+1)'(1));
        end else begin
            n     = q1 - s1;
            minus = 1'b1;
        end
        h = (n + (QW+1)'(1)) >> 1;
        return minus ? signed'(-h[OW-1:0]) : signed'(h[OW-1:0]);
    endfunction

endpackage

// ===== rtl/equal_circle_intersection.sv =====
// top level: pipelined intersection of two circles sharing a configured radius
`timescale 1ns / 1ps
// throughput: one request per cycle, busy is never raised
// the pipeline is a 26-stage root pipeline, one root bit per stage, plus six arithmetic stages
// reset: rst_n asynchronous, clears the radius to 0 and all stage valid bits
// results cannot be stalled by the receiver

module equal_circle_intersection (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [eci_pkg::CW-1:0]           first_center_x,
    input  logic [eci_pkg::CW-1:0]           first_center_y,
    input  logic [eci_pkg::CW-1:0]           second_center_x,
    input  logic [eci_pkg::CW-1:0]           second_center_y,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eci_pkg::CW-1:0]           cfg_data,
    output logic                             result_valid,
    output logic                             points_found,
    output logic signed [eci_pkg::OW-1:0]    point_one_x,
    output logic signed [eci_pkg::OW-1:0]    point_one_y,
    output logic signed [eci_pkg::OW-1:0]    point_two_x,
    output logic signed [eci_pkg::OW-1:0]    point_two_y
);
    import eci_pkg::*;

    logic [CW-1:0]  radius_reg;

    logic           s1_valid_reg;
    logic [CW-1:0]  s1_adx_reg, s1_ady_reg;
    logic           s1_dx_neg_reg, s1_dy_neg_reg;
    logic [SW-1:0]  s1_sum_x_reg, s1_sum_y_reg;
    logic [SW-1:0]  s1_r2_reg;

    logic           s2_valid_reg;
    logic [C2W-1:0] s2_ax2_reg, s2_ay2_reg;
    logic [D2W-1:0] s2_lim_reg;
    logic           s2_dx_neg_reg, s2_dy_neg_reg;
    logic [SW-1:0]  s2_sum_x_reg, s2_sum_y_reg;

    logic           s3_valid_reg;
    logic           s3_found_reg;
    logic [D2W-1:0] s3_d2_reg, s3_rem_reg;
    logic [C2W-1:0] s3_cx_reg, s3_cy_reg;
    logic           s3_dx_neg_reg, s3_dy_neg_reg;
    logic [SW-1:0]  s3_sum_x_reg, s3_sum_y_reg;
    logic [D2W-1:0] s3_d2_next;

    logic           s4_valid_reg;
    logic           s4_found_reg;
    logic [D2W-1:0] s4_d2_reg;
    logic [PPW-1:0] s4_px_reg [4];
    logic [PPW-1:0] s4_py_reg [4];
    logic           s4_dx_neg_reg, s4_dy_neg_reg;
    logic [SW-1:0]  s4_sum_x_reg, s4_sum_y_reg;

    logic           sq_valid_reg [QW+1];
    root_t          sq_reg       [QW+1];
    root_t          sq_next      [QW+1];

    logic           out_valid_reg;
    logic           out_found_reg;
    logic signed [OW-1:0] out_1x_reg, out_1y_reg, out_2x_reg, out_2y_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg    <= start && !busy;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            sq_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < QW; k++)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            out_valid_reg <= sq_valid_reg[QW];
        end
    end

    // differences, sums, doubled radius
    always_ff @(posedge clk)
    begin
        s1_dx_neg_reg <= second_center_x < first_center_x;
        s1_dy_neg_reg <= second_center_y < first_center_y;
        s1_adx_reg    <= (second_center_x < first_center_x) ?
                         first_center_x - second_center_x : second_center_x - first_center_x;
        s1_ady_reg    <= (second_center_y < first_center_y) ?
                         first_center_y - second_center_y : second_center_y - first_center_y;
        s1_sum_x_reg  <= SW'(first_center_x) + SW'(second_center_x);
        s1_sum_y_reg  <= SW'(first_center_y) + SW'(second_center_y);
        s1_r2_reg     <= {radius_reg, 1'b0};
    end

    // squares
    always_ff @(posedge clk)
    begin
        s2_ax2_reg    <= s1_adx_reg * s1_adx_reg;
        s2_ay2_reg    <= s1_ady_reg * s1_ady_reg;
        s2_lim_reg    <= s1_r2_reg * s1_r2_reg;
        s2_dx_neg_reg <= s1_dx_neg_reg;
        s2_dy_neg_reg <= s1_dy_neg_reg;
        s2_sum_x_reg  <= s1_sum_x_reg;
        s2_sum_y_reg  <= s1_sum_y_reg;
    end

    // distance test and remainder
    assign s3_d2_next = D2W'(s2_ax2_reg) + D2W'(s2_ay2_reg);

    always_ff @(posedge clk)
    begin
        s3_d2_reg     <= s3_d2_next;
        s3_found_reg  <= (s3_d2_next != '0) && (s3_d2_next <= s2_lim_reg);
        s3_rem_reg    <= (s3_d2_next <= s2_lim_reg) ? s2_lim_reg - s3_d2_next : '0;
        s3_cx_reg     <= s2_ay2_reg;
        s3_cy_reg     <= s2_ax2_reg;
        s3_dx_neg_reg <= s2_dx_neg_reg;
        s3_dy_neg_reg <= s2_dy_neg_reg;
        s3_sum_x_reg  <= s2_sum_x_reg;
        s3_sum_y_reg  <= s2_sum_y_reg;
    end

    // partial products of c^2 * rem
    always_ff @(posedge clk)
    begin
        s4_px_reg[0]  <= s3_cx_reg[CW-1:0]   * s3_rem_reg[LO_W-1:0];
        s4_px_reg[1]  <= s3_cx_reg[CW-1:0]   * s3_rem_reg[D2W-1:LO_W];
        s4_px_reg[2]  <= s3_cx_reg[C2W-1:CW] * s3_rem_reg[LO_W-1:0];
        s4_px_reg[3]  <= s3_cx_reg[C2W-1:CW] * s3_rem_reg[D2W-1:LO_W];
        s4_py_reg[0]  <= s3_cy_reg[CW-1:0]   * s3_rem_reg[LO_W-1:0];
        s4_py_reg[1]  <= s3_cy_reg[CW-1:0]   * s3_rem_reg[D2W-1:LO_W];
        s4_py_reg[2]  <= s3_cy_reg[C2W-1:CW] * s3_rem_reg[LO_W-1:0];
        s4_py_reg[3]  <= s3_cy_reg[C2W-1:CW] * s3_rem_reg[D2W-1:LO_W];
        s4_found_reg  <= s3_found_reg;
        s4_d2_reg     <= s3_d2_reg;
        s4_dx_neg_reg <= s3_dx_neg_reg;
        s4_dy_neg_reg <= s3_dy_neg_reg;
        s4_sum_x_reg  <= s3_sum_x_reg;
        s4_sum_y_reg  <= s3_sum_y_reg;
    end

    // root pipeline entry
    always_comb
    begin
        sq_next[0]        = '0;
        sq_next[0].found  = s4_found_reg;
        sq_next[0].dx_neg = s4_dx_neg_reg;
        sq_next[0].dy_neg = s4_dy_neg_reg;
        sq_next[0].sum_x  = s4_sum_x_reg;
        sq_next[0].sum_y  = s4_sum_y_reg;
        sq_next[0].d2     = s4_d2_reg;
        sq_next[0].rhs_x  = RHW'(s4_px_reg[0]) + (RHW'(s4_px_reg[1]) << LO_W)
                          + (RHW'(s4_px_reg[2]) << CW) + (RHW'(s4_px_reg[3]) << (CW + LO_W));
        sq_next[0].rhs_y  = RHW'(s4_py_reg[0]) + (RHW'(s4_py_reg[1]) << LO_W)
                          + (RHW'(s4_py_reg[2]) << CW) + (RHW'(s4_py_reg[3]) << (CW + LO_W));
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq_next[0];
    end

    // one root bit per stage, q^2*d2 and q*d2 kept incrementally
    for (genvar k = 0; k < QW; k++)
    begin : g_root
        localparam int B = QW - 1 - k;
        logic [AW-1:0] cand_x, cand_y, d2_w;

        always_comb
        begin
            d2_w   = AW'(sq_reg[k].d2);
            cand_x = sq_reg[k].s_x + (sq_reg[k].p_x << (B + 1)) + (d2_w << (2 * B));
            cand_y = sq_reg[k].s_y + (sq_reg[k].p_y << (B + 1)) + (d2_w << (2 * B));
            sq_next[k+1] = sq_reg[k];
            if (cand_x <= AW'(sq_reg[k].rhs_x))
            begin
                sq_next[k+1].s_x = cand_x;
                sq_next[k+1].p_x = sq_reg[k].p_x + (d2_w << B);
                sq_next[k+1].q_x = sq_reg[k].q_x | (QW'(1) << B);
            end
            if (cand_y <= AW'(sq_reg[k].rhs_y))
            begin
                sq_next[k+1].s_y = cand_y;
                sq_next[k+1].p_y = sq_reg[k].p_y + (d2_w << B);
                sq_next[k+1].q_y = sq_reg[k].q_y | (QW'(1) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next[k+1];
        end
    end

    // rounding and output register
    always_ff @(posedge clk)
    begin
        out_found_reg <= sq_reg[QW].found;
        if (sq_reg[QW].found)
        begin
            out_1x_reg <= half_round(sq_reg[QW].sum_x, sq_reg[QW].q_x, sq_reg[QW].dy_neg,
                                     sq_reg[QW].s_x == AW'(sq_reg[QW].rhs_x));
            out_1y_reg <= half_round(sq_reg[QW].sum_y, sq_reg[QW].q_y, !sq_reg[QW].dx_neg,
                                     sq_reg[QW].s_y == AW'(sq_reg[QW].rhs_y));
            out_2x_reg <= half_round(sq_reg[QW].sum_x, sq_reg[QW].q_x, !sq_reg[QW].dy_neg,
                                     sq_reg[QW].s_x == AW'(sq_reg[QW].rhs_x));
            out_2y_reg <= half_round(sq_reg[QW].sum_y, sq_reg[QW].q_y, sq_reg[QW].dx_neg,
                                     sq_reg[QW].s_y == AW'(sq_reg[QW].rhs_y));
        end
        else
        begin
            out_1x_reg <= '0;
            out_1y_reg <= '0;
            out_2x_reg <= '0;
            out_2y_reg <= '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign points_found = out_found_reg;
    assign point_one_x  = out_1x_reg;
    assign point_one_y  = out_1y_reg;
    assign point_two_x  = out_2x_reg;
    assign point_two_y  = out_2y_reg;

endmodule

// ===== rtl/eci_checker.sv =====
// checker: port level properties of the circle intersection block, bound to the top level
`timescale 1ns / 1ps

module eci_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          cfg_ready,
    input logic                          result_valid,
    input logic                          points_found,
    input logic signed [eci_pkg::OW-1:0] point_one_x,
    input logic signed [eci_pkg::OW-1:0] point_one_y,
    input logic signed [eci_pkg::OW-1:0] point_two_x,
    input logic signed [eci_pkg::OW-1:0] point_two_y
);
    import eci_pkg::*;

    a_no_result_without_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, LATENCY))
        else $error("result without a request");

    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !points_found) |->
        (point_one_x == '0 && point_one_y == '0 && point_two_x == '0 && point_two_y == '0))
        else $error("nonzero points without intersection");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("block stalled a request or a write");

endmodule

bind equal_circle_intersection eci_checker u_eci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .points_found (points_found),
    .point_one_x  (point_one_x),
    .point_one_y  (point_one_y),
    .point_two_x  (point_two_x),
    .point_two_y  (point_two_y)
);

// ===== bench/tb_equal_circle_intersection.sv =====
// testbench: random and directed checks of the equal radius circle intersection pipeline
`timescale 1ns / 1ps

module tb_equal_circle_intersection;

    import eci_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam logic [CW-1:0] COORD_MAX = '1;

    typedef struct {
        logic                 found;
        logic signed [OW-1:0] p1x;
        logic signed [OW-1:0] p1y;
        logic signed [OW-1:0] p2x;
        logic signed [OW-1:0] p2y;
    } points_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CW-1:0]        first_center_x;
    logic [CW-1:0]        first_center_y;
    logic [CW-1:0]        second_center_x;
    logic [CW-1:0]        second_center_y;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CW-1:0]        cfg_data;
    logic                 result_valid;
    logic                 points_found;
    logic signed [OW-1:0] point_one_x;
    logic signed [OW-1:0] point_one_y;
    logic signed [OW-1:0] point_two_x;
    logic signed [OW-1:0] point_two_y;

    points_t       expected_points[$];
    logic [CW-1:0] radius_model;
    int            mismatches;
    int            requests_sent;
    int            results_checked;
    int            hits_seen;
    int            cycle_count;
    bit            gaps_on;

    equal_circle_intersection i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .first_center_x  (first_center_x),
        .first_center_y  (first_center_y),
        .second_center_x (second_center_x),
        .second_center_y (second_center_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .points_found    (points_found),
        .point_one_x     (point_one_x),
        .point_one_y     (point_one_y),
        .point_two_x     (point_two_x),
        .point_two_y     (point_two_y)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one rounded coordinate: (sum +/- c*sqrt(rem/d2)) / 2, ties away from zero
    function automatic logic signed [OW-1:0] round_coord(
        input longint unsigned sum,
        input longint unsigned cmag,
        input bit              neg,
        input bit [127:0]      d2,
        input bit [127:0]      rem
    );
        bit [127:0]      cm;
        bit [127:0]      rhs;
        bit [127:0]      cand;
        bit [127:0]      q;
        bit              exact;
        longint unsigned n;
        longint          v;
        cm  = cmag;
        rhs = cm * cm * rem;
        q   = 0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = q | (128'd1 << b);
            if (cand * cand * d2 <= rhs)
                q = cand;
        end
        exact = (q * q * d2 == rhs);
        if (!neg)
        begin
            n = sum + q[63:0];
            v = longint'((n + 1) >> 1);
        end
        else if (exact ? (sum >= q[63:0]) : (sum > q[63:0]))
        begin
            n = sum - q[63:0] - (exact ? 0 : 1);
            v = longint'((n + 1) >> 1);
        end
        else
        begin
            n = q[63:0] - sum;
            v = -longint'((n + 1) >> 1);
        end
        if (v > (longint'(1) << (OW - 1)) - 1)
            v = (longint'(1) << (OW - 1)) - 1;
        if (v < -(longint'(1) << (OW - 1)))
            v = -(longint'(1) << (OW - 1));
        return v[OW-1:0];
    endfunction

    function automatic points_t predict_points(
        input logic [CW-1:0] x1,
        input logic [CW-1:0] y1,
        input logic [CW-1:0] x2,
        input logic [CW-1:0] y2
    );
        points_t         p;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned sx;
        longint unsigned sy;
        bit [127:0]      d2;
        bit [127:0]      lim;
        bit [127:0]      rem;
        bit              dx_neg;
        bit              dy_neg;
        adx    = (x1 > x2) ? x1 - x2 : x2 - x1;
        ady    = (y1 > y2) ? y1 - y2 : y2 - y1;
        dx_neg = x2 < x1;
        dy_neg = y2 < y1;
        sx     = longint'(x1) + longint'(x2);
        sy     = longint'(y1) + longint'(y2);
        d2     = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        lim    = 128'(radius_model) * 2;
        lim    = lim * lim;
        p      = '{1'b0, '0, '0, '0, '0};
        if (d2 == 0 || d2 > lim)
            return p;
        rem   = lim - d2;
        p.found = 1'b1;
        p.p1x = round_coord(sx, ady, dy_neg, d2, rem);
        p.p1y = round_coord(sy, adx, !dx_neg, d2, rem);
        p.p2x = round_coord(sx, ady, !dy_neg, d2, rem);
        p.p2y = round_coord(sy, adx, dx_neg, d2, rem);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        points_t e;
        if (rst_n && result_valid)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected result strobe", 1, 0);
            end
            else
            begin
                e = expected_points.pop_front();
                if (points_found !== e.found)
                    report_mismatch("points_found", points_found, e.found);
                if (point_one_x !== e.p1x)
                    report_mismatch("point_one_x", point_one_x, e.p1x);
                if (point_one_y !== e.p1y)
                    report_mismatch("point_one_y", point_one_y, e.p1y);
                if (point_two_x !== e.p2x)
                    report_mismatch("point_two_x", point_two_x, e.p2x);
                if (point_two_y !== e.p2y)
                    report_mismatch("point_two_y", point_two_y, e.p2y);
                if (e.found)
                    hits_seen++;
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(
        input logic [CW-1:0] x1,
        input logic [CW-1:0] y1,
        input logic [CW-1:0] x2,
        input logic [CW-1:0] y2
    );
        start           <= 1'b1;
        first_center_x  <= x1;
        first_center_y  <= y1;
        second_center_x <= x2;
        second_center_y <= y2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_points = {expected_points, predict_points(x1, y1, x2, y2)};
        requests_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 13));
    endtask

    task automatic drain;
        hold_off(1);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_radius(input logic [CW-1:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        radius_model = r;
        @(posedge clk);
    endtask

    function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c, input longint span);
        longint v;
        v = longint'(c) + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (v < 0)
            v = 0;
        if (v > longint'(COORD_MAX))
            v = longint'(COORD_MAX);
        return v[CW-1:0];
    endfunction

    task automatic test_directed;
        logic [CW-1:0] m;
        set_radius(24'd1280);
        m = 24'h800000;
        send_request(m, m, m, m);
        send_request(m, m, m + 24'd2560, m);
        send_request(m, m, m, m - 24'd2560);
        send_request(m, m, m + 24'd2561, m);
        send_request(m, m, m + 24'd1000, m + 24'd700);
        send_request(m + 24'd1000, m + 24'd700, m, m);
        send_request(m, m + 24'd33, m + 24'd17, m);
        send_request(24'd0, 24'd0, 24'd1, 24'd1);
        send_request(COORD_MAX, COORD_MAX, COORD_MAX - 24'd3, COORD_MAX);
        send_request(24'd0, COORD_MAX, COORD_MAX, 24'd0);
        set_radius(24'd0);
        send_request(m, m, m, m);
        send_request(m, m, m + 24'd1, m);
        send_request(24'd0, 24'd0, 24'd0, 24'd0);
        set_radius(COORD_MAX);
        send_request(24'd0, 24'd0, COORD_MAX, COORD_MAX);
        send_request(COORD_MAX, 24'd0, 24'd0, COORD_MAX);
        send_request(24'd0, 24'd0, COORD_MAX, 24'd0);
        send_request(COORD_MAX, COORD_MAX, 24'd0, COORD_MAX);
        send_request(24'd1, 24'd2, 24'd1, 24'd3);
        set_radius(24'd1);
        send_request(24'd5, 24'd5, 24'd7, 24'd5);
        send_request(24'd5, 24'd5, 24'd6, 24'd6);
        send_request(24'd5, 24'd5, 24'd5, 24'd4);
        hold_off(1);
    endtask

    task automatic test_random_radius(input logic [CW-1:0] r, input int count);
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
        longint        span;
        set_radius(r);
        span = (2 * longint'(r) > 2000000) ? 2000000 : 2 * longint'(r) + 2;
        for (int i = 0; i < count; i++)
        begin
            x1 = CW'($urandom());
            y1 = CW'($urandom());
            if ($urandom_range(0, 4) == 0)
                send_request(x1, y1, CW'($urandom()), CW'($urandom()));
            else if ($urandom_range(0, 19) == 0)
                send_request(x1, y1, x1, y1);
            else
                send_request(x1, y1, near_coord(x1, span), near_coord(y1, span));
        end
        hold_off(1);
    endtask

    task automatic test_pause_until_drained;
        for (int i = 0; i < 40; i++)
            send_request(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()));
        drain();
        for (int i = 0; i < 40; i++)
            send_request(CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()));
        hold_off(1);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        first_center_x  = '0;
        first_center_y  = '0;
        second_center_x = '0;
        second_center_y = '0;
        radius_model    = '0;
        requests_sent   = 0;
        gaps_on         = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_radius(24'd300, 300);
        test_random_radius(COORD_MAX, 250);
        test_random_radius(CW'($urandom_range(1, 255)), 250);
        test_pause_until_drained();
        test_random_radius(CW'($urandom()), 300);
        test_random_radius(CW'($urandom_range(1000, 200000)), 300);
        test_random_radius(24'd1, 150);
        gaps_on = 1'b0;
        test_random_radius(CW'($urandom_range(256, 65535)), 300);

        drain();
        $display("sent %0d requests over several radii incl. 0, 1 and full scale", requests_sent);
        $display("checked %0d results, %0d with intersection points", results_checked, hits_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/eci_pkg.sv
rtl/equal_circle_intersection.sv
rtl/eci_checker.sv
bench/tb_equal_circle_intersection.sv
